// ----- sv/mqa_pkg.sv -----
// Shared types, constants and helpers for the attitude update block.
`default_nettype none
package mqa_pkg;

  localparam int MW      = 37;  // multiplier operand width, signed
  localparam int EW      = 35;  // attitude error, Q30
  localparam int DW      = 36;  // quaternion derivative sum
  localparam int QNW     = 44;  // integrated quaternion before renormalisation
  localparam int MUL_STEPS  = MW;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [27:0] KP_RESET = 28'd14260634;
  localparam logic [27:0] KI_RESET = 28'd33554;
  localparam logic [23:0] HP_RESET = 24'd41943;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  localparam logic [1:0] CFG_KP = 2'd0;
  localparam logic [1:0] CFG_KI = 2'd1;
  localparam logic [1:0] CFG_HP = 2'd2;

  typedef enum logic [1:0] {AR_MUL, AR_DIV, AR_SQRT} ar_op_t;

  typedef struct packed {
    logic   start;
    ar_op_t op;
  } ar_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GRAV, ST_NSHIFT, ST_NSQ, ST_NSQRT, ST_NDIV, ST_CROSS,
    ST_INT, ST_PROP, ST_DER, ST_QINT, ST_QCHK, ST_OUT
  } st_t;

  // one term of the quaternion derivative: d[dst] +/-= q[qi] * g[gj]
  typedef struct packed {
    logic [1:0] dst;
    logic [1:0] qi;
    logic [1:0] gj;
    logic       neg;
  } der_t;

  function automatic der_t der_term(input logic [3:0] i);
    der_t t;
    case (i)
      4'd0:    t = '{dst: 2'd0, qi: 2'd1, gj: 2'd0, neg: 1'b1};
      4'd1:    t = '{dst: 2'd0, qi: 2'd2, gj: 2'd1, neg: 1'b1};
      4'd2:    t = '{dst: 2'd0, qi: 2'd3, gj: 2'd2, neg: 1'b1};
      4'd3:    t = '{dst: 2'd1, qi: 2'd0, gj: 2'd0, neg: 1'b0};
      4'd4:    t = '{dst: 2'd1, qi: 2'd2, gj: 2'd2, neg: 1'b0};
      4'd5:    t = '{dst: 2'd1, qi: 2'd3, gj: 2'd1, neg: 1'b1};
      4'd6:    t = '{dst: 2'd2, qi: 2'd0, gj: 2'd1, neg: 1'b0};
      4'd7:    t = '{dst: 2'd2, qi: 2'd1, gj: 2'd2, neg: 1'b1};
      4'd8:    t = '{dst: 2'd2, qi: 2'd3, gj: 2'd0, neg: 1'b0};
      4'd9:    t = '{dst: 2'd3, qi: 2'd0, gj: 2'd2, neg: 1'b0};
      4'd10:   t = '{dst: 2'd3, qi: 2'd1, gj: 2'd1, neg: 1'b0};
      4'd11:   t = '{dst: 2'd3, qi: 2'd2, gj: 2'd0, neg: 1'b1};
      default: t = '{dst: 2'd0, qi: 2'd0, gj: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [QNW-1:0] mag_of(input logic signed [QNW-1:0] x);
    logic [QNW-1:0] r;
    r = x[QNW-1] ? QNW'(-x) : QNW'(x);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/mahony_quaternion_attitude_update.sv -----
// Top level: sequencer, state and register file of the attitude update.
// All arithmetic runs through one shared unit (multiply, divide, square root),
// with shifts that normalise each vector first; a skipped request ends after
// the gravity estimate.
// Throughput: one request at a time; s_tready only while idle.
// Reset (synchronous): identity quaternion, integrals zero, gains to defaults.
`default_nettype none
module mahony_quaternion_attitude_update
  import mqa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z (32 bits each)
  input  wire logic [191:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // quat_w, quat_x, quat_y, quat_z, gravity_x, gravity_y, gravity_z (32 bits each)
  output logic [223:0]      m_tdata,
  // update_skipped
  output logic [0:0]        m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [27:0]  cfg_data
);

  st_t state, state_next;
  logic        pending;
  logic [3:0]  idx, count;
  logic        last, wb, ar_done;
  ar_ctl_t     ctl;
  logic signed [MW-1:0] opa, opb;
  logic [63:0] num;
  logic signed [63:0] ar_res, ps;

  logic [27:0] kp, ki;
  logic [23:0] hp;
  logic signed [31:0]    q [4];
  logic signed [31:0]    ei [3];
  logic signed [31:0]    gr [3];
  logic signed [31:0]    ac [3];
  logic signed [31:0]    v [3];
  logic signed [31:0]    an [3];
  logic signed [EW-1:0]  e [3];
  logic signed [DW-1:0]  d [4];
  logic signed [QNW-1:0] qn [4];
  logic [QNW-1:0]        mag [4];
  logic [63:0]           sum;
  logic [31:0]           root;
  logic signed [63:0]    tmp;
  logic                  uvq, skip;

  logic [QNW-1:0]     mmax;
  logic               too_big, too_small, skip_now, qzero, cneg;
  logic signed [31:0] divc;
  der_t               dt;

  mqa_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .a    (opa),
    .b    (opb),
    .num  (num),
    .den  (root),
    .done (ar_done),
    .res  (ar_res)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign wb        = pending && ar_done;
  assign last      = (idx == count - 4'd1);
  assign ps        = ar_res >>> 30;
  assign dt        = der_term(idx);

  always_comb begin
    mmax = '0;
    for (int i = 0; i < 4; i++) begin
      if (mag[i] > mmax) mmax = mag[i];
    end
    too_big   = (mmax[QNW-1:31] != '0);
    too_small = !mmax[30];
    skip_now  = (ac[0] == 0) || (ac[1] == 0) || (ac[2] == 0);
    qzero     = (qn[0] == 0) && (qn[1] == 0) && (qn[2] == 0) && (qn[3] == 0);
    cneg      = uvq ? qn[idx[1:0]][QNW-1] : ac[idx[1:0]][31];
    divc      = cneg ? -$signed({1'b0, ar_res[30:0]}) : $signed({1'b0, ar_res[30:0]});
    num       = sum;
    if (state == ST_NDIV) num = {3'b000, mag[idx[1:0]][30:0], 30'd0};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_GRAV;
      ST_GRAV:   if (wb && last) state_next = skip_now ? ST_OUT : ST_NSHIFT;
      ST_NSHIFT: if (!too_big && !too_small) state_next = ST_NSQ;
      ST_NSQ:    if (wb && last) state_next = ST_NSQRT;
      ST_NSQRT:  if (wb) state_next = ST_NDIV;
      ST_NDIV:   if (wb && last) state_next = uvq ? ST_OUT : ST_CROSS;
      ST_CROSS:  if (wb && last) state_next = ST_INT;
      ST_INT:    if (wb && last) state_next = ST_PROP;
      ST_PROP:   if (wb && last) state_next = ST_DER;
      ST_DER:    if (wb && last) state_next = ST_QINT;
      ST_QINT:   if (wb && last) state_next = ST_QCHK;
      ST_QCHK:   state_next = qzero ? ST_OUT : ST_NSHIFT;
      ST_OUT:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // unit requests and operand selection
  always_comb begin
    ctl.start = 1'b0;
    ctl.op    = AR_MUL;
    opa       = '0;
    opb       = '0;
    count     = 4'd1;
    case (state)
      ST_GRAV: begin
        ctl.start = !pending;
        count     = 4'd6;
        case (idx)
          4'd0:    begin opa = MW'(q[1]); opb = MW'(q[3]); end
          4'd1:    begin opa = MW'(q[0]); opb = MW'(q[2]); end
          4'd2:    begin opa = MW'(q[2]); opb = MW'(q[3]); end
          4'd3:    begin opa = MW'(q[0]); opb = MW'(q[1]); end
          4'd4:    begin opa = MW'(q[1]); opb = MW'(q[1]); end
          default: begin opa = MW'(q[2]); opb = MW'(q[2]); end
        endcase
      end
      ST_NSQ: begin
        ctl.start = !pending;
        count     = uvq ? 4'd4 : 4'd3;
        opa       = MW'(mag[idx[1:0]][30:0]);
        opb       = MW'(mag[idx[1:0]][30:0]);
      end
      ST_NSQRT: begin
        ctl.start = !pending;
        ctl.op    = AR_SQRT;
      end
      ST_NDIV: begin
        ctl.start = !pending;
        ctl.op    = AR_DIV;
        count     = uvq ? 4'd4 : 4'd3;
      end
      ST_CROSS: begin
        ctl.start = !pending;
        count     = 4'd6;
        case (idx)
          4'd0:    begin opa = MW'(an[1]); opb = MW'(v[2]); end
          4'd1:    begin opa = MW'(an[2]); opb = MW'(v[1]); end
          4'd2:    begin opa = MW'(an[2]); opb = MW'(v[0]); end
          4'd3:    begin opa = MW'(an[0]); opb = MW'(v[2]); end
          4'd4:    begin opa = MW'(an[0]); opb = MW'(v[1]); end
          default: begin opa = MW'(an[1]); opb = MW'(v[0]); end
        endcase
      end
      ST_INT: begin
        ctl.start = !pending;
        count     = 4'd3;
        opa       = MW'(e[idx[1:0]]);
        opb       = MW'(ki);
      end
      ST_PROP: begin
        ctl.start = !pending;
        count     = 4'd3;
        opa       = MW'(e[idx[1:0]]);
        opb       = MW'(kp);
      end
      ST_DER: begin
        ctl.start = !pending;
        count     = 4'd12;
        opa       = MW'(q[dt.qi]);
        opb       = MW'(gr[dt.gj]);
      end
      ST_QINT: begin
        ctl.start = !pending;
        count     = 4'd4;
        opa       = MW'(d[idx[1:0]]);
        opb       = MW'(hp);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= 1'b0;
      idx      <= '0;
      kp       <= KP_RESET;
      ki       <= KI_RESET;
      hp       <= HP_RESET;
      q[0]     <= 32'sd1073741824;
      q[1]     <= '0;
      q[2]     <= '0;
      q[3]     <= '0;
      ei[0]    <= '0;
      ei[1]    <= '0;
      ei[2]    <= '0;
      m_tvalid <= 1'b0;
      uvq      <= 1'b0;
      skip     <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.start) pending <= 1'b1;
      else if (ar_done) pending <= 1'b0;
      if (wb) idx <= last ? '0 : idx + 4'd1;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_KP:  kp <= cfg_data;
          CFG_KI:  ki <= cfg_data;
          CFG_HP:  hp <= cfg_data[23:0];
          default: ;
        endcase
      end

      if (state == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            gr[0] <= s_tdata[31:0];
            gr[1] <= s_tdata[63:32];
            gr[2] <= s_tdata[95:64];
            ac[0] <= s_tdata[127:96];
            ac[1] <= s_tdata[159:128];
            ac[2] <= s_tdata[191:160];
          end
        end
        ST_GRAV: begin
          if (wb) begin
            case (idx)
              4'd1:    v[0] <= sat32((tmp - ps) <<< 1);
              4'd3:    v[1] <= sat32((tmp + ps) <<< 1);
              4'd5:    v[2] <= sat32(ONE_Q30 - ((tmp + ps) <<< 1));
              default: tmp  <= ps;
            endcase
            if (last) begin
              skip   <= skip_now;
              uvq    <= 1'b0;
              mag[0] <= mag_of(QNW'(ac[0]));
              mag[1] <= mag_of(QNW'(ac[1]));
              mag[2] <= mag_of(QNW'(ac[2]));
              mag[3] <= '0;
            end
          end
        end
        ST_NSHIFT: begin
          for (int i = 0; i < 4; i++) begin
            if (too_big) mag[i] <= mag[i] >> 1;
            else if (too_small) mag[i] <= mag[i] << 1;
          end
          sum <= '0;
        end
        ST_NSQ:   if (wb) sum <= sum + ar_res;
        ST_NSQRT: if (wb) root <= ar_res[31:0];
        ST_NDIV: begin
          if (wb) begin
            if (uvq) q[idx[1:0]] <= divc;
            else an[idx[1:0]] <= divc;
          end
        end
        ST_CROSS: begin
          if (wb) begin
            if (!idx[0]) tmp <= ar_res;
            else e[idx[2:1]] <= EW'((tmp - ar_res) >>> 30);
          end
        end
        ST_INT: begin
          if (wb) ei[idx[1:0]] <= sat32(64'(ei[idx[1:0]]) + ps);
        end
        ST_PROP: begin
          if (wb) begin
            gr[idx[1:0]] <= sat32(64'(gr[idx[1:0]]) + ps + 64'(ei[idx[1:0]]));
            if (last) begin
              for (int i = 0; i < 4; i++) d[i] <= '0;
            end
          end
        end
        ST_DER: begin
          if (wb) begin
            if (dt.neg) d[dt.dst] <= d[dt.dst] - DW'(ps);
            else d[dt.dst] <= d[dt.dst] + DW'(ps);
          end
        end
        ST_QINT: begin
          if (wb) qn[idx[1:0]] <= QNW'(q[idx[1:0]]) + QNW'(ar_res >>> 18);
        end
        ST_QCHK: begin
          if (!qzero) begin
            for (int i = 0; i < 4; i++) mag[i] <= mag_of(qn[i]);
            uvq <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {v[2], v[1], v[0], q[3], q[2], q[1], q[0]};
            m_tuser  <= skip;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) ar_done |-> pending)
    else $error("result from shared unit with no request outstanding");
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !pending)
    else $error("idle with shared unit still busy");
  assert property (@(posedge clk) disable iff (rst) (state == ST_NSHIFT) |-> (mmax != '0))
    else $error("normalising an all-zero vector");
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_NDIV && wb) |-> (ar_res[63:31] == '0))
    else $error("unit vector component out of range");

endmodule
`default_nettype wire

// ----- sv/mqa_arith.sv -----
// Shared multi-cycle unit: shift-add multiply, restoring divide, integer square root.
`default_nettype none
module mqa_arith
  import mqa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ar_ctl_t               ctl,
  input  wire logic signed [MW-1:0]  a,
  input  wire logic signed [MW-1:0]  b,
  input  wire logic [63:0]           num,
  input  wire logic [31:0]           den,
  output logic                       done,
  output logic signed [63:0]         res
);

  logic          busy;
  logic [6:0]    cnt;
  ar_op_t        op_r;
  logic          neg;
  logic [63:0]   x, y, z;
  logic [31:0]   dv;
  logic [MW-1:0] ma, mb;
  logic [32:0]   rr;
  logic [63:0]   st;
  logic          last;

  always_comb begin
    ma = a[MW-1] ? MW'(-a) : MW'(a);
    mb = b[MW-1] ? MW'(-b) : MW'(b);
    rr = {z[31:0], x[63]};
    st = y + z;
    case (op_r)
      AR_MUL:  last = (cnt == 7'(MUL_STEPS - 1));
      AR_DIV:  last = (cnt == 7'(DIV_STEPS - 1));
      default: last = (cnt == 7'(SQRT_STEPS - 1));
    endcase
    case (op_r)
      AR_MUL:  res = neg ? -$signed(z) : $signed(z);
      default: res = $signed(y);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op_r <= ctl.op;
        dv   <= den;
        case (ctl.op)
          AR_MUL: begin
            x   <= 64'(ma);
            y   <= 64'(mb);
            z   <= '0;
            neg <= a[MW-1] ^ b[MW-1];
          end
          AR_DIV: begin
            x <= num;
            y <= '0;
            z <= '0;
          end
          default: begin
            x <= num;
            y <= '0;
            z <= 64'h4000_0000_0000_0000;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        case (op_r)
          AR_MUL: begin
            if (y[0]) z <= z + x;
            x <= x << 1;
            y <= y >> 1;
          end
          AR_DIV: begin
            x <= x << 1;
            if (rr >= {1'b0, dv}) begin
              z <= 64'(rr - {1'b0, dv});
              y <= {y[62:0], 1'b1};
            end else begin
              z <= 64'(rr);
              y <= {y[62:0], 1'b0};
            end
          end
          default: begin
            if (x >= st) begin
              x <= x - st;
              y <= (y >> 1) + z;
            end else begin
              y <= y >> 1;
            end
            z <= z >> 2;
          end
        endcase
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("arith start while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("arith done while busy");
  assert property (@(posedge clk) disable iff (rst) ctl.start |=> busy)
    else $error("arith start did not take");

endmodule
`default_nettype wire
